// ===== sv/zod_pkg.sv =====
`timescale 1ns / 1ps

package zod_pkg;

    // default sizing of the store and the amount word
    localparam int DEPTH_DEF       = 64;
    localparam int AMOUNT_BITS_DEF = 28;

    // fixed port widths
    localparam int AMT_W = 28;
    localparam int IDX_W = 6;
    localparam int ZL_W  = 4;

    // threshold after reset, in standard deviations
    localparam logic [ZL_W-1:0] Z_RESET = 4'd3;

    // sequencer states, one-hot
    typedef enum logic [6:0] {
        ST_LOAD  = 7'b0000001,
        ST_DIVM  = 7'b0000010,
        ST_PASS1 = 7'b0000100,
        ST_DIVV  = 7'b0001000,
        ST_ROOTI = 7'b0010000,
        ST_ROOT  = 7'b0100000,
        ST_PASS2 = 7'b1000000
    } zod_state_t;

endpackage

// ===== sv/zod_ram.sv =====
`timescale 1ns / 1ps

module zod_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/zscore_outlier_detector_core.sv =====
`timescale 1ns / 1ps
// load: one amount per cycle while busy is low, one store write per beat while the store has room
// after the last beat: 62-step mean divide, a store pass, 62-step variance divide,
// one setup step and a 28-step square root, then a result pass of one beat per cycle
// (default sizing); busy is high from the mean divide through the result pass
// results are strobed one cycle each and the receiver cannot stall them
// rst_n is asynchronous, active low: clears count, sum, overflow flag, sequencer, z_limit=3

module zscore_outlier_detector_core
    import zod_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int AMOUNT_BITS = AMOUNT_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [AMT_W-1:0] amount,
    input  logic                    last,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [ZL_W-1:0]         cfg_data,
    output logic                    result_valid,
    output logic [IDX_W-1:0]        item_index,
    output logic signed [AMT_W-1:0] item_amount,
    output logic                    is_anomaly,
    output logic signed [AMT_W-1:0] mean_value,
    output logic [AMT_W-1:0]        std_dev,
    output logic                    dropped,
    output logic                    end_of_set
);

    localparam int A         = AMOUNT_BITS;
    localparam int IDX_BITS  = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int SUM_BITS  = A + IDX_BITS + 1;
    localparam int SQ_BITS   = 2 * A;
    localparam int SS_BITS   = SQ_BITS + IDX_BITS;
    localparam int DIV_BITS  = SS_BITS;
    localparam int DCNT_BITS = $clog2(DIV_BITS);
    localparam int RCNT_BITS = $clog2(A);
    localparam int K2_BITS   = 2 * ZL_W;
    localparam int KSS_BITS  = SS_BITS + K2_BITS;
    localparam int LHS_BITS  = SQ_BITS + CNT_BITS;

    // control state
    zod_state_t                  state_reg, state_next;
    logic [CNT_BITS-1:0]         count_reg, count_next;
    logic signed [SUM_BITS-1:0]  sum_reg, sum_next;
    logic                        ovf_reg, ovf_next;
    logic [ZL_W-1:0]             z_reg;
    logic [DCNT_BITS-1:0]        dcnt_reg, dcnt_next;
    logic [RCNT_BITS-1:0]        rcnt_reg, rcnt_next;
    logic [CNT_BITS-1:0]         iss_reg, iss_next;
    logic                        p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg, out_v_reg;

    // datapath state
    logic [DIV_BITS-1:0]         dq_reg, dq_next;
    logic [CNT_BITS-1:0]         rem_reg, rem_next;
    logic                        sneg_reg, sneg_next;
    logic [SS_BITS-1:0]          ss_reg, ss_next;
    logic signed [A-1:0]         mean_reg;
    logic [SQ_BITS-1:0]          rt_rem_reg, rt_rem_next;
    logic [SQ_BITS-1:0]          rt_res_reg, rt_res_next;
    logic [SQ_BITS-1:0]          rt_bit_reg, rt_bit_next;
    logic [K2_BITS-1:0]          k2_reg;
    logic [KSS_BITS-1:0]         kss_reg;

    // pass pipeline payload
    logic [IDX_BITS-1:0]         idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic                        lst1_reg, lst2_reg, lst3_reg, lst4_reg;
    logic signed [A-1:0]         x2_reg, x3_reg, x4_reg;
    logic signed [A:0]           d_reg;
    logic [SQ_BITS-1:0]          sq_reg;
    logic [LHS_BITS-1:0]         lhs_reg;

    // result registers
    logic [IDX_W-1:0]            o_idx_reg;
    logic signed [AMT_W-1:0]     o_amt_reg;
    logic                        o_flag_reg;
    logic signed [AMT_W-1:0]     o_mean_reg;
    logic [AMT_W-1:0]            o_sd_reg;
    logic                        o_drop_reg;
    logic                        o_last_reg;

    // store port
    logic                        ram_we;
    logic                        ram_re;
    logic [A-1:0]                ram_rdata;

    // combinational helpers
    logic                        accept;
    logic                        store_ok;
    logic signed [A-1:0]         amt_in;
    logic signed [SUM_BITS-1:0]  sum_add;
    logic signed [SUM_BITS-1:0]  load_sum;
    logic [SUM_BITS-1:0]         load_mag;
    logic [CNT_BITS:0]           rem_sh;
    logic                        qbit;
    logic [CNT_BITS-1:0]         rem_step;
    logic [DIV_BITS-1:0]         dq_step;
    logic                        div_done;
    logic [SQ_BITS-1:0]          rt_trial;
    logic                        rt_ge;
    logic                        issue;
    logic                        pass_active;
    logic                        pipe_empty;
    logic signed [A-1:0]         mean_calc;
    logic signed [A-1:0]         rd_s;
    logic [A-1:0]                d_mag;
    logic [KSS_BITS-1:0]         kss_prod;
    logic                        flag_calc;

    assign busy      = (state_reg != ST_LOAD);
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign store_ok  = (count_reg < CNT_BITS'(DEPTH));
    assign amt_in    = amount[A-1:0];
    assign sum_add   = sum_reg + SUM_BITS'(amt_in);
    assign load_sum  = store_ok ? sum_add : sum_reg;
    assign load_mag  = load_sum[SUM_BITS-1] ? SUM_BITS'(-load_sum) : SUM_BITS'(load_sum);

    // restoring divide step by the item count, one quotient bit per cycle
    assign rem_sh   = {rem_reg, dq_reg[DIV_BITS-1]};
    assign qbit     = (rem_sh >= {1'b0, count_reg});
    assign rem_step = qbit ? CNT_BITS'(rem_sh - {1'b0, count_reg}) : CNT_BITS'(rem_sh);
    assign dq_step  = {dq_reg[DIV_BITS-2:0], qbit};
    assign div_done = (dcnt_reg == DCNT_BITS'(DIV_BITS - 1));

    // square root step, two radicand bits per cycle
    assign rt_trial = rt_res_reg + rt_bit_reg;
    assign rt_ge    = (rt_rem_reg >= rt_trial);

    // mean from the quotient, sign restored
    assign mean_calc = sneg_reg ? -$signed(dq_reg[A-1:0]) : $signed(dq_reg[A-1:0]);

    // store read issue for both passes
    assign pass_active = (state_reg == ST_PASS1) || (state_reg == ST_PASS2);
    assign issue       = pass_active && (iss_reg != count_reg);
    assign pipe_empty  = !p1_v_reg && !p2_v_reg && !p3_v_reg;
    assign ram_re      = issue;
    assign ram_we      = accept && store_ok;

    assign rd_s     = ram_rdata;
    assign d_mag    = d_reg[A] ? A'(-d_reg) : A'(d_reg);
    assign kss_prod = ss_reg * k2_reg;
    assign flag_calc = (ss_reg != '0) && (KSS_BITS'(lhs_reg) > kss_reg);

    zod_ram #(
        .WIDTH (A),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_BITS-1:0]),
        .wdata (amount[A-1:0]),
        .re    (ram_re),
        .raddr (iss_reg[IDX_BITS-1:0]),
        .rdata (ram_rdata)
    );

    // sequencer and next-state logic
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        ovf_next    = ovf_reg;
        dcnt_next   = dcnt_reg;
        rcnt_next   = rcnt_reg;
        iss_next    = iss_reg;
        dq_next     = dq_reg;
        rem_next    = rem_reg;
        sneg_next   = sneg_reg;
        ss_next     = ss_reg;
        rt_rem_next = rt_rem_reg;
        rt_res_next = rt_res_reg;
        rt_bit_next = rt_bit_reg;

        if (issue)
        begin
            iss_next = iss_reg + CNT_BITS'(1);
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (store_ok)
                    begin
                        count_next = count_reg + CNT_BITS'(1);
                        sum_next   = sum_add;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last)
                    begin
                        state_next = ST_DIVM;
                        dq_next    = DIV_BITS'(load_mag);
                        rem_next   = '0;
                        dcnt_next  = '0;
                        sneg_next  = load_sum[SUM_BITS-1];
                        ss_next    = '0;
                        iss_next   = '0;
                    end
                end
            end
            ST_DIVM:
            begin
                dq_next   = dq_step;
                rem_next  = rem_step;
                dcnt_next = dcnt_reg + DCNT_BITS'(1);
                if (div_done)
                begin
                    state_next = ST_PASS1;
                end
            end
            ST_PASS1:
            begin
                if (p3_v_reg)
                begin
                    ss_next = ss_reg + SS_BITS'(sq_reg);
                end
                if ((iss_reg == count_reg) && pipe_empty)
                begin
                    state_next = ST_DIVV;
                    dq_next    = ss_reg;
                    rem_next   = '0;
                    dcnt_next  = '0;
                end
            end
            ST_DIVV:
            begin
                dq_next   = dq_step;
                rem_next  = rem_step;
                dcnt_next = dcnt_reg + DCNT_BITS'(1);
                if (div_done)
                begin
                    state_next = ST_ROOTI;
                end
            end
            ST_ROOTI:
            begin
                rt_rem_next = dq_reg[SQ_BITS-1:0];
                rt_res_next = '0;
                rt_bit_next = SQ_BITS'(1) << (SQ_BITS - 2);
                rcnt_next   = '0;
                state_next  = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (rt_ge)
                begin
                    rt_rem_next = rt_rem_reg - rt_trial;
                    rt_res_next = (rt_res_reg >> 1) + rt_bit_reg;
                end
                else
                begin
                    rt_res_next = rt_res_reg >> 1;
                end
                rt_bit_next = rt_bit_reg >> 2;
                rcnt_next   = rcnt_reg + RCNT_BITS'(1);
                if (rcnt_reg == RCNT_BITS'(A - 1))
                begin
                    state_next = ST_PASS2;
                    iss_next   = '0;
                end
            end
            ST_PASS2:
            begin
                if ((iss_reg == count_reg) && pipe_empty)
                begin
                    state_next = ST_LOAD;
                    count_next = '0;
                    sum_next   = '0;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
            z_reg     <= Z_RESET;
            dcnt_reg  <= '0;
            rcnt_reg  <= '0;
            iss_reg   <= '0;
            ss_reg    <= '0;
            p1_v_reg  <= 1'b0;
            p2_v_reg  <= 1'b0;
            p3_v_reg  <= 1'b0;
            p4_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            ovf_reg   <= ovf_next;
            dcnt_reg  <= dcnt_next;
            rcnt_reg  <= rcnt_next;
            iss_reg   <= iss_next;
            ss_reg    <= ss_next;
            if (cfg_valid && cfg_ready)
            begin
                z_reg <= cfg_data;
            end
            p1_v_reg  <= issue;
            p2_v_reg  <= p1_v_reg;
            p3_v_reg  <= p2_v_reg;
            p4_v_reg  <= p3_v_reg && (state_reg == ST_PASS2);
            out_v_reg <= p4_v_reg;
        end
    end

    // arithmetic units and pass pipeline
    always_ff @(posedge clk)
    begin
        dq_reg     <= dq_next;
        rem_reg    <= rem_next;
        sneg_reg   <= sneg_next;
        rt_rem_reg <= rt_rem_next;
        rt_res_reg <= rt_res_next;
        rt_bit_reg <= rt_bit_next;

        // threshold square, then scaled spread
        k2_reg <= K2_BITS'(z_reg) * K2_BITS'(z_reg);
        if (state_reg == ST_ROOTI)
        begin
            kss_reg <= kss_prod;
        end

        if (state_reg == ST_PASS1)
        begin
            mean_reg <= mean_calc;
        end

        // read issued
        idx1_reg <= iss_reg[IDX_BITS-1:0];
        lst1_reg <= (iss_reg == count_reg - CNT_BITS'(1));

        // deviation from the mean
        idx2_reg <= idx1_reg;
        lst2_reg <= lst1_reg;
        x2_reg   <= rd_s;
        d_reg    <= (A + 1)'(rd_s) - (A + 1)'(mean_reg);

        // squared deviation
        idx3_reg <= idx2_reg;
        lst3_reg <= lst2_reg;
        x3_reg   <= x2_reg;
        sq_reg   <= d_mag * d_mag;

        // scaled by the count
        idx4_reg <= idx3_reg;
        lst4_reg <= lst3_reg;
        x4_reg   <= x3_reg;
        lhs_reg  <= sq_reg * count_reg;

        // result beat
        o_idx_reg  <= IDX_W'(idx4_reg);
        o_amt_reg  <= AMT_W'(x4_reg);
        o_flag_reg <= flag_calc;
        o_mean_reg <= AMT_W'(mean_reg);
        o_sd_reg   <= AMT_W'(rt_res_reg[A-1:0]);
        o_drop_reg <= ovf_reg;
        o_last_reg <= lst4_reg;
    end

    assign result_valid = out_v_reg;
    assign item_index   = o_idx_reg;
    assign item_amount  = o_amt_reg;
    assign is_anomaly   = o_flag_reg;
    assign mean_value   = o_mean_reg;
    assign std_dev      = o_sd_reg;
    assign dropped      = o_drop_reg;
    assign end_of_set   = o_last_reg;

endmodule

// ===== sv/zod_checker.sv =====
`timescale 1ns / 1ps

module zod_checker
    import zod_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    result_valid,
    input logic [IDX_W-1:0]        item_index,
    input logic signed [AMT_W-1:0] item_amount,
    input logic                    is_anomaly,
    input logic signed [AMT_W-1:0] mean_value,
    input logic [AMT_W-1:0]        std_dev,
    input logic                    dropped,
    input logic                    end_of_set
);

    // a burst of results opens at the first item
    a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> (item_index == '0))
        else $error("result burst does not start at item zero");

    // results of one set come back to back in index order
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !end_of_set) |=>
            (result_valid && (item_index == IDX_W'($past(item_index) + IDX_W'(1)))))
        else $error("result beat missing or out of order");

    // set-wide statistics hold across the burst
    a_set_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !end_of_set) |=>
            ($stable(mean_value) && $stable(std_dev) && $stable(dropped)))
        else $error("set statistics changed within a burst");

    // the end of set closes the burst
    a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && end_of_set) |=> !result_valid)
        else $error("result beat after end of set");

    // an item equal to the mean is never flagged
    a_flag_dev: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && is_anomaly) |-> (item_amount != mean_value))
        else $error("item at the mean flagged as anomaly");

endmodule

bind zscore_outlier_detector_core zod_checker u_zod_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .item_index   (item_index),
    .item_amount  (item_amount),
    .is_anomaly   (is_anomaly),
    .mean_value   (mean_value),
    .std_dev      (std_dev),
    .dropped      (dropped),
    .end_of_set   (end_of_set)
);
